[rtl/core/tcpo_pkg.sv]
package tcpo_pkg;

  // field widths
  localparam int unsigned ByteW  = 8;
  localparam int unsigned LenW   = 6;
  localparam int unsigned CodeW  = 4;
  localparam int unsigned WordW  = 32;
  localparam int unsigned ShiftW = 64;

  // result codes
  typedef enum logic [CodeW-1:0] {
    CODE_EOL      = 4'd0,
    CODE_NOP      = 4'd1,
    CODE_MSS      = 4'd2,
    CODE_WSCALE   = 4'd3,
    CODE_SACKOK   = 4'd4,
    CODE_SACK_HDR = 4'd5,
    CODE_SACK_BLK = 4'd6,
    CODE_TSTAMP   = 4'd7,
    CODE_FASTOPEN = 4'd8,
    CODE_UNK_HDR  = 4'd9,
    CODE_DATA     = 4'd10,
    CODE_BAD_KIND = 4'd11,
    CODE_BAD_LEN  = 4'd12
  } code_e;

  // option kinds
  localparam logic [ByteW-1:0] KindEol      = 8'd0;
  localparam logic [ByteW-1:0] KindNop      = 8'd1;
  localparam logic [ByteW-1:0] KindMss      = 8'd2;
  localparam logic [ByteW-1:0] KindWscale   = 8'd3;
  localparam logic [ByteW-1:0] KindSackOk   = 8'd4;
  localparam logic [ByteW-1:0] KindSack     = 8'd5;
  localparam logic [ByteW-1:0] KindTstamp   = 8'd8;
  localparam logic [ByteW-1:0] KindFastOpen = 8'd34;

  // fixed option lengths and the minimum option length
  localparam logic [LenW-1:0] LenMss    = 6'd4;
  localparam logic [LenW-1:0] LenWscale = 6'd3;
  localparam logic [LenW-1:0] LenTstamp = 6'd10;
  localparam logic [LenW-1:0] LenMin    = 6'd2;

  // classified byte handed from front to back
  typedef struct packed {
    logic              emit;   // produces a result
    logic              shift;  // body byte, goes into the value shifter
    code_e             code;
    logic [ByteW-1:0]  kind;
    logic [ByteW-1:0]  data;   // body byte or length byte, zero otherwise
    logic              stop;
  } op_t;

  typedef struct packed {
    code_e             code;
    logic [ByteW-1:0]  kind;
    logic [WordW-1:0]  value_a;
    logic [WordW-1:0]  value_b;
    logic              stop;
  } res_t;

endpackage

[rtl/core/tcpo_if.sv]
interface tcpo_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] opt_byte;
  logic [5:0] area_len;
  logic       first_byte;

  modport source (output valid, opt_byte, area_len, first_byte, input ready);
  modport sink   (input valid, opt_byte, area_len, first_byte, output ready);
endinterface

interface tcpo_out_if;
  logic        valid;
  logic        ready;
  logic [3:0]  code;
  logic [7:0]  kind;
  logic [31:0] value_a;
  logic [31:0] value_b;
  logic        stop;

  modport source (output valid, code, kind, value_a, value_b, stop, input ready);
  modport sink   (input valid, code, kind, value_a, value_b, stop, output ready);
endinterface

[rtl/core/tcp_option_parser.sv]
// tcp options parser
// in_i: one options byte per request, with the area length and a first-byte
//   flag; the first byte of an area restarts the parse and latches the length
//   (saturated at MAX_AREA_BYTES)
// out_o: zero or one result per byte: code, kind, value_a, value_b and stop
// the front walks the kind/length records and classifies each byte, a
//   two-entry queue holds classified bytes, the back keeps a 64-bit shifter
//   of option body bytes and drives the registered result
// throughput: one byte per cycle while the queue is not full, set by the front record walker
// result path: an accepted byte is written into the queue, then its result is
//   loaded into the output register; while the receiver stalls the result
//   waits there
// receiver stall: the output register holds its result, the queue fills once
//   two more queued bytes wait behind it and in_i.ready then drops until
//   results drain
// bytes with no result that are not option body bytes never enter the queue
// reset: no area is open, so bytes are ignored until a first byte arrives;
//   the queue and output register come up empty
module tcp_option_parser #(
  parameter int unsigned MAX_AREA_BYTES = 40
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  tcpo_in_if.sink     in_i,
  tcpo_out_if.source  out_o
);

  logic           q_full;
  logic           q_push;
  tcpo_pkg::op_t  push_op;
  logic           q_valid;
  tcpo_pkg::op_t  pop_op;
  logic           q_pop;
  logic           res_valid;
  tcpo_pkg::res_t res;

  // record walker and byte classifier
  tcpo_front #(
    .MAX_AREA_BYTES(MAX_AREA_BYTES)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (in_i.valid),
    .ready_o     (in_i.ready),
    .opt_byte_i  (in_i.opt_byte),
    .area_len_i  (in_i.area_len),
    .first_byte_i(in_i.first_byte),
    .q_full_i    (q_full),
    .push_o      (q_push),
    .op_o        (push_op)
  );

  // decouples the walker from output stalls
  tcpo_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (q_push),
    .push_op_i(push_op),
    .full_o   (q_full),
    .valid_o  (q_valid),
    .pop_op_o (pop_op),
    .pop_i    (q_pop)
  );

  // value assembly and result register
  tcpo_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_valid_i  (q_valid),
    .q_op_i     (pop_op),
    .q_pop_o    (q_pop),
    .out_valid_o(res_valid),
    .out_ready_i(out_o.ready),
    .res_o      (res)
  );

  assign out_o.valid   = res_valid;
  assign out_o.code    = res.code;
  assign out_o.kind    = res.kind;
  assign out_o.value_a = res.value_a;
  assign out_o.value_b = res.value_b;
  assign out_o.stop    = res.stop;

endmodule

[rtl/core/tcpo_front.sv]
module tcpo_front #(
  parameter int unsigned MAX_AREA_BYTES = 40
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         valid_i,
  output logic                         ready_o,
  input  logic [tcpo_pkg::ByteW-1:0]   opt_byte_i,
  input  logic [tcpo_pkg::LenW-1:0]    area_len_i,
  input  logic                         first_byte_i,
  input  logic                         q_full_i,
  output logic                         push_o,
  output tcpo_pkg::op_t                op_o
);

  localparam logic [tcpo_pkg::LenW-1:0] MaxLen = tcpo_pkg::LenW'(MAX_AREA_BYTES);

  typedef enum logic [1:0] {
    PH_KIND,
    PH_LEN,
    PH_BODY
  } phase_e;

  phase_e                     phase_q, phase_d, ph_eff;
  logic [tcpo_pkg::LenW-1:0]  off_q, off_d, off_eff;
  logic [tcpo_pkg::LenW-1:0]  len_q, len_d, len_eff;
  logic [tcpo_pkg::LenW-1:0]  olen_q, olen_d;
  logic [tcpo_pkg::LenW-1:0]  bidx_q, bidx_d;
  logic [tcpo_pkg::ByteW-1:0] kind_q, kind_d;
  logic                       stopped_q, stopped_d, stop_eff;
  logic                       accept;
  logic                       needs_push;
  logic                       is_known;
  logic [8:0]                 rec_end;
  logic [tcpo_pkg::ByteW-1:0] b;

  assign ready_o = !q_full_i;
  assign accept  = valid_i && ready_o;
  assign b       = opt_byte_i;
  assign push_o  = accept && needs_push;

  assign is_known = (kind_q == tcpo_pkg::KindMss) || (kind_q == tcpo_pkg::KindWscale) ||
                    (kind_q == tcpo_pkg::KindSackOk) || (kind_q == tcpo_pkg::KindSack) ||
                    (kind_q == tcpo_pkg::KindTstamp) || (kind_q == tcpo_pkg::KindFastOpen);

  // end of record measured from its kind byte, one before the length byte
  assign rec_end = 9'(off_eff) - 9'd1 + 9'(b);

  always_comb begin
    // restart on the first byte of a new area
    if (first_byte_i) begin
      len_eff  = (area_len_i > MaxLen) ? MaxLen : area_len_i;
      off_eff  = '0;
      ph_eff   = PH_KIND;
      stop_eff = (len_eff == '0);
    end else begin
      len_eff  = len_q;
      off_eff  = off_q;
      ph_eff   = phase_q;
      stop_eff = stopped_q;
    end

    phase_d    = ph_eff;
    off_d      = off_eff;
    len_d      = len_eff;
    stopped_d  = stop_eff;
    olen_d     = olen_q;
    bidx_d     = bidx_q;
    kind_d     = kind_q;
    needs_push = 1'b0;
    op_o       = '{emit: 1'b0, shift: 1'b0, code: tcpo_pkg::CODE_EOL,
                   kind: '0, data: '0, stop: 1'b0};

    if (!stop_eff && (off_eff < len_eff)) begin
      off_d = off_eff + 6'd1;
      unique case (ph_eff)
        PH_KIND: begin
          if (b == tcpo_pkg::KindEol) begin
            stopped_d  = 1'b1;
            needs_push = 1'b1;
            op_o.emit  = 1'b1;
            op_o.code  = tcpo_pkg::CODE_EOL;
            op_o.stop  = 1'b1;
          end else if (b == tcpo_pkg::KindNop) begin
            needs_push = 1'b1;
            op_o.emit  = 1'b1;
            op_o.code  = tcpo_pkg::CODE_NOP;
            op_o.kind  = tcpo_pkg::KindNop;
          end else if (7'(off_eff) + 7'd1 >= 7'(len_eff)) begin
            // kind byte with no room for its length
            stopped_d  = 1'b1;
            needs_push = 1'b1;
            op_o.emit  = 1'b1;
            op_o.code  = tcpo_pkg::CODE_BAD_KIND;
            op_o.kind  = b;
            op_o.stop  = 1'b1;
          end else begin
            kind_d  = b;
            phase_d = PH_LEN;
          end
        end
        PH_LEN: begin
          op_o.kind = kind_q;
          op_o.data = b;
          if ((b < 8'(tcpo_pkg::LenMin)) || (b > 8'(len_eff)) || (rec_end > 9'(len_eff))) begin
            stopped_d  = 1'b1;
            needs_push = 1'b1;
            op_o.emit  = 1'b1;
            op_o.code  = tcpo_pkg::CODE_BAD_LEN;
            op_o.stop  = 1'b1;
          end else begin
            olen_d  = b[tcpo_pkg::LenW-1:0];
            bidx_d  = 6'd2;
            phase_d = (b == 8'(tcpo_pkg::LenMin)) ? PH_KIND : PH_BODY;
            if (kind_q == tcpo_pkg::KindSackOk) begin
              needs_push = 1'b1;
              op_o.emit  = 1'b1;
              op_o.code  = tcpo_pkg::CODE_SACKOK;
            end else if (kind_q == tcpo_pkg::KindFastOpen) begin
              needs_push = 1'b1;
              op_o.emit  = 1'b1;
              op_o.code  = tcpo_pkg::CODE_FASTOPEN;
            end else if (kind_q == tcpo_pkg::KindSack) begin
              needs_push = 1'b1;
              op_o.emit  = 1'b1;
              op_o.code  = tcpo_pkg::CODE_SACK_HDR;
            end else if (!is_known) begin
              needs_push = 1'b1;
              op_o.emit  = 1'b1;
              op_o.code  = tcpo_pkg::CODE_UNK_HDR;
            end
          end
        end
        PH_BODY: begin
          needs_push = 1'b1;
          op_o.shift = 1'b1;
          op_o.kind  = kind_q;
          op_o.data  = b;
          if (kind_q == tcpo_pkg::KindMss) begin
            op_o.emit = (olen_q == tcpo_pkg::LenMss) && (bidx_q == 6'd3);
            op_o.code = tcpo_pkg::CODE_MSS;
          end else if (kind_q == tcpo_pkg::KindWscale) begin
            op_o.emit = (olen_q == tcpo_pkg::LenWscale) && (bidx_q == 6'd2);
            op_o.code = tcpo_pkg::CODE_WSCALE;
          end else if (kind_q == tcpo_pkg::KindTstamp) begin
            op_o.emit = (olen_q == tcpo_pkg::LenTstamp) && (bidx_q == 6'd9);
            op_o.code = tcpo_pkg::CODE_TSTAMP;
          end else if (kind_q == tcpo_pkg::KindSack) begin
            // eighth byte of a sack block
            op_o.emit = (3'(bidx_q - 6'd2) == 3'd7);
            op_o.code = tcpo_pkg::CODE_SACK_BLK;
          end else if ((kind_q != tcpo_pkg::KindSackOk) &&
                       (kind_q != tcpo_pkg::KindFastOpen)) begin
            op_o.emit = 1'b1;
            op_o.code = tcpo_pkg::CODE_DATA;
          end
          bidx_d = bidx_q + 6'd1;
          if (7'(bidx_q) + 7'd1 >= 7'(olen_q)) begin
            phase_d = PH_KIND;
          end
        end
        default: begin
          phase_d = PH_KIND;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_KIND;
      off_q     <= '0;
      len_q     <= '0;
      olen_q    <= '0;
      bidx_q    <= '0;
      kind_q    <= '0;
      stopped_q <= 1'b1;
    end else if (accept) begin
      phase_q   <= phase_d;
      off_q     <= off_d;
      len_q     <= len_d;
      olen_q    <= olen_d;
      bidx_q    <= bidx_d;
      kind_q    <= kind_d;
      stopped_q <= stopped_d;
    end
  end

endmodule

[rtl/core/tcpo_queue.sv]
module tcpo_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  tcpo_pkg::op_t push_op_i,
  output logic          full_o,
  output logic          valid_o,
  output tcpo_pkg::op_t pop_op_o,
  input  logic          pop_i
);

  // two-entry fifo
  tcpo_pkg::op_t mem_q [2];
  logic          wr_ptr_q, rd_ptr_q;
  logic [1:0]    cnt_q;
  logic          do_push, do_pop;

  assign full_o   = (cnt_q == 2'd2);
  assign valid_o  = (cnt_q != 2'd0);
  assign pop_op_o = mem_q[rd_ptr_q];
  assign do_push  = push_i && !full_o;
  assign do_pop   = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_op_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (do_pop) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      case ({do_push, do_pop})
        2'b10:   cnt_q <= cnt_q + 2'd1;
        2'b01:   cnt_q <= cnt_q - 2'd1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

[rtl/core/tcpo_back.sv]
module tcpo_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           q_valid_i,
  input  tcpo_pkg::op_t  q_op_i,
  output logic           q_pop_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output tcpo_pkg::res_t res_o
);

  logic [tcpo_pkg::ShiftW-1:0] sh_q, sh_new;
  logic                        out_valid_q;
  tcpo_pkg::res_t              res_q, res_d;

  // results leave only when the output register frees up
  assign q_pop_o     = q_valid_i && (!q_op_i.emit || !out_valid_q || out_ready_i);
  assign out_valid_o = out_valid_q;
  assign res_o       = res_q;
  assign sh_new      = {sh_q[tcpo_pkg::ShiftW-9:0], q_op_i.data};

  always_comb begin
    res_d.code    = q_op_i.code;
    res_d.kind    = q_op_i.kind;
    res_d.stop    = q_op_i.stop;
    res_d.value_a = {24'd0, q_op_i.data};
    res_d.value_b = '0;
    case (q_op_i.code)
      tcpo_pkg::CODE_MSS: begin
        res_d.value_a = {16'd0, sh_new[15:0]};
      end
      tcpo_pkg::CODE_TSTAMP, tcpo_pkg::CODE_SACK_BLK: begin
        res_d.value_a = sh_new[63:32];
        res_d.value_b = sh_new[31:0];
      end
      default: begin
        res_d.value_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o && q_op_i.shift) begin
      sh_q <= sh_new;
    end
    if (q_pop_o && q_op_i.emit) begin
      res_q <= res_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (q_pop_o && q_op_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

endmodule
